[hw/rtl/vefm_pkg.sv]
// shared constants and types for the voxel exposed-face mask block
`timescale 1ns / 1ps
`default_nettype none

package vefm_pkg;

  localparam int MAX_DIM   = 16;
  localparam int MAX_CELLS = 4096;

  localparam int ADDR_W  = $clog2(MAX_CELLS);       // cell address
  localparam int CNT_W   = ADDR_W + 1;              // load count, cell total
  localparam int DIM_W   = 5;                       // dimension registers
  localparam int COORD_W = $clog2(MAX_DIM);         // x, y, z coordinates
  localparam int CHAN_W  = 8;
  localparam int WORD_W  = 3 * CHAN_W + 1;          // fill bit and colour
  localparam int POS_W   = 6;
  localparam int MASK_W  = 6;
  localparam int DIV_CNT_W = $clog2(ADDR_W + 1);

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;
  localparam logic [1:0] REG_TINT   = 2'd3;

  // input commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   wdata;
  } mem_req_t;

  typedef struct packed {
    logic                done;
    logic [ADDR_W-1:0]   quot;
    logic [DIM_W-1:0]    rem;
  } div_res_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/vefm_store.sv]
// single-port voxel store: fill bit and colour per cell, registered read
`timescale 1ns / 1ps
`default_nettype none

module vefm_store
  import vefm_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_req_t          req,
  output logic [WORD_W-1:0]      rdata
);

  logic [WORD_W-1:0] mem [MAX_CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/vefm_div.sv]
// bit-serial restoring divider: cell index by a grid dimension
`timescale 1ns / 1ps
`default_nettype none

module vefm_div
  import vefm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [ADDR_W-1:0]  dividend,
  input  wire logic [DIM_W-1:0]   divisor,
  output div_res_t                res
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIM_W-1:0]      dsr;
  logic [DIM_W-1:0]      rem;
  logic [ADDR_W-1:0]     quot;
  logic                  done;

  logic [DIM_W:0]        r_sh;
  logic                  ge;
  logic [DIM_W:0]        r_sub;
  logic [DIM_W-1:0]      rem_next;

  always_comb begin
    r_sh     = {rem, quot[ADDR_W-1]};
    ge       = (r_sh >= {1'b0, dsr});
    r_sub    = r_sh - {1'b0, dsr};
    rem_next = ge ? r_sub[DIM_W-1:0] : r_sh[DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[ADDR_W-2:0], ge};
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem;

endmodule

`default_nettype wire

[hw/rtl/voxel_exposed_face_mask.sv]
// top level: voxel load, cell scan with neighbour reads, result register
`timescale 1ns / 1ps
`default_nettype none

// Voxel exposed-face mask. A load word (cmd 0) writes the next cell of the
// grid in x, then z, then y order; loads past the cell count are dropped.
// A scan word (cmd 1) visits the next cell and yields one result: fill bit,
// colour, the six-face exposure mask and the centred position. The
// single-port voxel store is read once per cycle, for the cell itself and
// then its six neighbours. The scan position is kept as x, y, z counters;
// after a write to the width or length register the first scan rebuilds
// them with two 12-step serial divisions before its reads. Fill bits of
// cells beyond the load count read as empty, so no clearing pass is needed
// after reset. The result register lets the next word be accepted while a
// result waits to be taken.
module voxel_exposed_face_mask
  import vefm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [DIM_W-1:0]   cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic [CHAN_W-1:0]  red,
  input  wire logic [CHAN_W-1:0]  green,
  input  wire logic [CHAN_W-1:0]  blue,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    cell_filled,
  output logic [CHAN_W-1:0]       out_red,
  output logic [CHAN_W-1:0]       out_green,
  output logic [CHAN_W-1:0]       out_blue,
  output logic [MASK_W-1:0]       face_mask,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z,
  output logic                    last_cell
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // read steps: the cell, then its neighbours in face-mask bit order
  localparam logic [2:0] RD_CENTRE = 3'd0;
  localparam logic [2:0] RD_XM     = 3'd1;
  localparam logic [2:0] RD_XP     = 3'd2;
  localparam logic [2:0] RD_ZP     = 3'd3;
  localparam logic [2:0] RD_ZM     = 3'd4;
  localparam logic [2:0] RD_YP     = 3'd5;
  localparam logic [2:0] RD_YM     = 3'd6;
  localparam logic [2:0] RD_END    = 3'd7;

  // configuration registers
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  logic [DIM_W-1:0] grid_length;
  logic             tint_mode;

  logic [DIM_W-1:0]     w_eff, h_eff, l_eff;
  logic [2*DIM_W-1:0]   wl;
  logic [3*DIM_W-1:0]   prod;
  logic [CNT_W-1:0]     total;

  always_comb begin
    w_eff = eff_dim(grid_width);
    h_eff = eff_dim(grid_height);
    l_eff = eff_dim(grid_length);
    wl    = w_eff * l_eff;
    prod  = wl * h_eff;
    total = (prod > (3*DIM_W)'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : prod[CNT_W-1:0];
  end

  // control state
  logic [2:0]          state;
  logic [CNT_W-1:0]    load_count;
  logic [ADDR_W-1:0]   scan_count;
  logic [ADDR_W-1:0]   idx;
  logic [COORD_W-1:0]  x, y, z;
  logic                coord_ok;
  logic [2:0]          rd_step;
  logic                rd_pend;
  logic [2:0]          rd_k;
  logic                rd_ok;

  // gathered result
  logic                 filled;
  logic [3*CHAN_W-1:0]  colour;
  logic [MASK_W-1:0]    mask;

  mem_req_t            req;
  logic [WORD_W-1:0]   rdata;
  div_res_t            div_res;
  logic                div_start;
  logic [ADDR_W-1:0]   div_dividend;
  logic [DIM_W-1:0]    div_divisor;

  logic                in_acc;
  logic                scan_acc;
  logic                load_acc;
  logic                scan_wrap;
  logic                load_fill;
  logic                out_free;
  logic                rd_issue;
  logic [CNT_W-1:0]    nb_addr;
  logic                nb_in;
  logic                is_last;
  logic [ADDR_W-1:0]   idx_inc;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign scan_acc  = in_acc && (cmd == CMD_SCAN);
  assign load_acc  = in_acc && (cmd == CMD_LOAD) && (load_count < total);
  assign scan_wrap = ({1'b0, scan_count} >= total);
  assign out_free  = !out_valid || !out_stall;
  assign rd_issue  = (state == S_READ) && (rd_step != RD_END);
  assign idx_inc   = idx + ADDR_W'(1);
  assign is_last   = ({1'b0, idx} + CNT_W'(1) == total);

  assign load_fill = tint_mode ? ((red != '0) && (green != '0) && (blue != '0))
                               : ((red != '0) || (green != '0) || (blue != '0));

  // neighbour address and in-grid check for the current read step
  always_comb begin
    unique case (rd_step)
      RD_CENTRE: begin
        nb_addr = {1'b0, idx};
        nb_in   = 1'b1;
      end
      RD_XM: begin
        nb_addr = {1'b0, idx} - CNT_W'(1);
        nb_in   = (x != '0);
      end
      RD_XP: begin
        nb_addr = {1'b0, idx} + CNT_W'(1);
        nb_in   = ({1'b0, x} + DIM_W'(1) < w_eff);
      end
      RD_ZP: begin
        nb_addr = {1'b0, idx} + CNT_W'(w_eff);
        nb_in   = ({1'b0, z} + DIM_W'(1) < l_eff);
      end
      RD_ZM: begin
        nb_addr = {1'b0, idx} - CNT_W'(w_eff);
        nb_in   = (z != '0);
      end
      RD_YP: begin
        nb_addr = {1'b0, idx} + CNT_W'(wl);
        nb_in   = ({1'b0, y} + DIM_W'(1) < h_eff);
      end
      RD_YM: begin
        nb_addr = {1'b0, idx} - CNT_W'(wl);
        nb_in   = (y != '0);
      end
      default: begin
        nb_addr = {1'b0, idx};
        nb_in   = 1'b0;
      end
    endcase
  end

  always_comb begin
    req.we    = load_acc;
    req.re    = rd_issue;
    req.addr  = load_acc ? load_count[ADDR_W-1:0] : nb_addr[ADDR_W-1:0];
    req.wdata = {load_fill, red, green, blue};
  end

  always_comb begin
    div_start    = (scan_acc && !scan_wrap && !coord_ok) ||
                   ((state == S_DIV1) && div_res.done);
    div_dividend = (state == S_IDLE) ? scan_count : div_res.quot;
    div_divisor  = (state == S_IDLE) ? w_eff : l_eff;
  end

  vefm_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  vefm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(1);
      grid_height <= DIM_W'(1);
      grid_length <= DIM_W'(1);
      tint_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  grid_width  <= cfg_data;
        REG_HEIGHT: grid_height <= cfg_data;
        REG_LENGTH: grid_length <= cfg_data;
        REG_TINT:   tint_mode   <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_count <= '0;
      scan_count <= '0;
      idx        <= '0;
      x          <= '0;
      y          <= '0;
      z          <= '0;
      coord_ok   <= 1'b1;
      rd_step    <= RD_CENTRE;
      rd_pend    <= 1'b0;
      rd_k       <= RD_CENTRE;
      rd_ok      <= 1'b0;
    end else begin
      // coordinates go stale when the x or z extent changes
      if (cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_LENGTH))) begin
        coord_ok <= 1'b0;
      end
      if (load_acc) begin
        load_count <= load_count + CNT_W'(1);
      end
      rd_pend <= rd_issue;
      if (rd_issue) begin
        rd_k    <= rd_step;
        rd_ok   <= nb_in && ({1'b0, nb_addr[ADDR_W-1:0]} < load_count);
        rd_step <= rd_step + 3'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (scan_acc) begin
            rd_step <= RD_CENTRE;
            if (scan_wrap) begin
              idx      <= '0;
              x        <= '0;
              y        <= '0;
              z        <= '0;
              coord_ok <= 1'b1;
              state    <= S_READ;
            end else begin
              idx   <= scan_count;
              state <= coord_ok ? S_READ : S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_res.done) begin
            x     <= div_res.rem[COORD_W-1:0];
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_res.done) begin
            z        <= div_res.rem[COORD_W-1:0];
            y        <= div_res.quot[COORD_W-1:0];
            coord_ok <= 1'b1;
            state    <= S_READ;
          end
        end
        S_READ: begin
          if (rd_pend && (rd_k == RD_YM)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
            // step x, then z, then y; the last cell goes back to the origin
            if (is_last) begin
              scan_count <= '0;
              x          <= '0;
              y          <= '0;
              z          <= '0;
            end else begin
              scan_count <= idx_inc;
              if ({1'b0, x} + DIM_W'(1) == w_eff) begin
                x <= '0;
                if ({1'b0, z} + DIM_W'(1) == l_eff) begin
                  z <= '0;
                  y <= y + COORD_W'(1);
                end else begin
                  z <= z + COORD_W'(1);
                end
              end else begin
                x <= x + COORD_W'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // gather fill, colour and face bits as read data returns
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      if (rd_k == RD_CENTRE) begin
        filled <= rdata[WORD_W-1] && rd_ok;
        colour <= rdata[3*CHAN_W-1:0];
      end else begin
        mask[rd_k - 3'd1] <= !(rdata[WORD_W-1] && rd_ok);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      cell_filled <= filled;
      out_red     <= filled ? colour[3*CHAN_W-1:2*CHAN_W] : '0;
      out_green   <= filled ? colour[2*CHAN_W-1:CHAN_W] : '0;
      out_blue    <= filled ? colour[CHAN_W-1:0] : '0;
      face_mask   <= mask;
      pos_x       <= POS_W'(w_eff[DIM_W-1:1]) - POS_W'(x);
      pos_y       <= POS_W'(y) - POS_W'(h_eff[DIM_W-1:1]);
      pos_z       <= POS_W'(z) - POS_W'(l_eff[DIM_W-1:1]);
      last_cell   <= is_last;
    end
  end

`ifndef SYNTH
  // the store port is never asked to read and write at once
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(req.we && req.re))
    else $error("store read and write in the same cycle");

  // read data only returns while the scan is gathering
  a_rd_in_read: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_READ))
    else $error("read data returned outside the read phase");

  // scan coordinates stay inside the grid while neighbours are read
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |->
      (({1'b0, x} < w_eff) && ({1'b0, z} < l_eff) && ({1'b0, y} < h_eff)))
    else $error("scan coordinates outside the grid");

  // a load is only written below the cell count
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    req.we |-> (load_count < total))
    else $error("load written past the cell count");
`endif

endmodule

`default_nettype wire
